@@ rtl/zobkey_pkg.sv @@
`default_nettype none

package zobkey_pkg;

   // Random table layout of the opening-book key.
   localparam int TableDepth = 781;
   localparam int IdxW       = $clog2(TableDepth);
   localparam logic [IdxW-1:0] CastleBase = IdxW'(768);
   localparam logic [IdxW-1:0] EpBase     = IdxW'(772);
   localparam logic [IdxW-1:0] TurnWord   = IdxW'(780);
   localparam logic [IdxW-1:0] LastIndex  = IdxW'(TableDepth - 1);

   localparam int KeyW = 64;

   // Characters with a meaning in the position string.
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChOne   = 8'h31;
   localparam logic [7:0] ChEight = 8'h38;
   localparam logic [7:0] ChLowA  = 8'h61;
   localparam logic [7:0] ChLowH  = 8'h68;
   localparam logic [7:0] ChLowW  = 8'h77;
   localparam logic [7:0] ChWK    = 8'h4B;
   localparam logic [7:0] ChWQ    = 8'h51;
   localparam logic [7:0] ChBK    = 8'h6B;
   localparam logic [7:0] ChBQ    = 8'h71;

   // Piece codes in table order.
   localparam logic [3:0] PcBlackPawn = 4'd0;
   localparam logic [3:0] PcWhitePawn = 4'd1;

   // Which field of the position string is being parsed.
   typedef enum logic [2:0] {
      PH_BOARD  = 3'd0,
      PH_SIDE   = 3'd1,
      PH_CASTLE = 3'd2,
      PH_EP     = 3'd3,
      PH_REST   = 3'd4
   } phase_type;

   // What the parser hands to the table lookup stage for one character.
   typedef struct packed {
      logic            hit;   // XOR the addressed table word into the key
      logic [IdxW-1:0] addr;  // table word address
      logic            bad;   // bad-piece flag including this character
      logic            last;  // final character: emit the key
   } lookup_type;

   // Piece letter to table code; bit 4 set when the letter is a piece.
   function automatic logic [4:0] piece_code(input logic [7:0] c);
      logic [4:0] r;
      case (c)
         8'h70:   r = {1'b1, 4'd0};  // p
         8'h50:   r = {1'b1, 4'd1};  // P
         8'h6E:   r = {1'b1, 4'd2};  // n
         8'h4E:   r = {1'b1, 4'd3};  // N
         8'h62:   r = {1'b1, 4'd4};  // b
         8'h42:   r = {1'b1, 4'd5};  // B
         8'h72:   r = {1'b1, 4'd6};  // r
         8'h52:   r = {1'b1, 4'd7};  // R
         8'h71:   r = {1'b1, 4'd8};  // q
         8'h51:   r = {1'b1, 4'd9};  // Q
         8'h6B:   r = {1'b1, 4'd10}; // k
         8'h4B:   r = {1'b1, 4'd11}; // K
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/zobkey_parse.sv @@
`default_nettype none

// Position string parser. Tracks field, rank and file, and for each accepted
// character names the table word (if any) that enters the key.
module zobkey_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   char_en,
   input  wire logic [7:0]             char_code,
   input  wire logic                   is_last,
   output      zobkey_pkg::lookup_type lookup
);
   import zobkey_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [2:0] rank_ff, rank_in;
   logic [3:0] file_ff, file_in;
   logic       wtm_ff, wtm_in;
   logic [7:0] bp4_ff, bp4_in;
   logic [7:0] wp5_ff, wp5_in;
   logic       bad_ff, bad_in;

   logic [4:0] pc;
   logic [4:0] file_sum;
   logic [3:0] file_count;
   logic       is_digit;
   logic       is_ep_file;
   logic [2:0] ep_file;
   logic [7:0] ep_onehot;
   logic [7:0] beside;
   logic [7:0] pawns;
   logic       char_bad;

   // Shared decode.
   always_comb begin
      pc         = piece_code(char_code);
      is_digit   = (char_code >= ChOne) && (char_code <= ChEight);
      file_sum   = {1'b0, file_ff} + {1'b0, char_code[3:0]};
      file_count = (file_ff < 4'd15) ? file_ff + 4'd1 : file_ff;
      is_ep_file = (char_code >= ChLowA) && (char_code <= ChLowH);
      ep_file    = char_code[2:0] - 3'd1;
      ep_onehot  = 8'd1 << ep_file;
      beside     = (ep_onehot << 1) | (ep_onehot >> 1);
      pawns      = wtm_ff ? wp5_ff : bp4_ff;
      char_bad   = (phase_ff == PH_BOARD) && (char_code != ChSpace) &&
                   (char_code != ChSlash) && !is_digit && !pc[4];
   end

   // Next state of the parse registers.
   always_comb begin
      phase_in = phase_ff;
      rank_in  = rank_ff;
      file_in  = file_ff;
      wtm_in   = wtm_ff;
      bp4_in   = bp4_ff;
      wp5_in   = wp5_ff;
      bad_in   = bad_ff | char_bad;
      if (char_code == ChSpace) begin
         case (phase_ff)
            PH_BOARD:  phase_in = PH_SIDE;
            PH_SIDE:   phase_in = PH_CASTLE;
            PH_CASTLE: phase_in = PH_EP;
            default:   phase_in = PH_REST;
         endcase
         file_in = 4'd0;
      end else begin
         case (phase_ff)
            PH_BOARD: begin
               if (char_code == ChSlash) begin
                  rank_in = rank_ff - 3'd1;
                  file_in = 4'd0;
               end else if (is_digit) begin
                  file_in = (file_sum > 5'd8) ? 4'd8 : file_sum[3:0];
               end else begin
                  if (pc[4] && file_ff < 4'd8) begin
                     if (pc[3:0] == PcBlackPawn && rank_ff == 3'd3) begin
                        bp4_in[file_ff[2:0]] = 1'b1;
                     end
                     if (pc[3:0] == PcWhitePawn && rank_ff == 3'd4) begin
                        wp5_in[file_ff[2:0]] = 1'b1;
                     end
                  end
                  if (file_ff < 4'd8) begin
                     file_in = file_ff + 4'd1;
                  end
               end
            end
            PH_SIDE: begin
               if (file_ff == 4'd0) begin
                  wtm_in = (char_code == ChLowW);
               end
               file_in = file_count;
            end
            PH_CASTLE, PH_EP: begin
               file_in = file_count;
            end
            default: begin
            end
         endcase
      end
      if (is_last) begin
         phase_in = PH_BOARD;
         rank_in  = 3'd7;
         file_in  = 4'd0;
         wtm_in   = 1'b0;
         bp4_in   = 8'd0;
         wp5_in   = 8'd0;
         bad_in   = 1'b0;
      end
   end

   // Lookup for the current character.
   always_comb begin
      lookup.hit  = 1'b0;
      lookup.addr = {pc[3:0], rank_ff, file_ff[2:0]};
      lookup.bad  = bad_ff | char_bad;
      lookup.last = is_last;
      if (char_code != ChSpace) begin
         case (phase_ff)
            PH_BOARD: begin
               lookup.hit = (char_code != ChSlash) && !is_digit && pc[4] &&
                            (file_ff < 4'd8);
            end
            PH_SIDE: begin
               lookup.addr = TurnWord;
               lookup.hit  = (file_ff == 4'd0) && (char_code == ChLowW);
            end
            PH_CASTLE: begin
               lookup.hit = 1'b1;
               case (char_code)
                  ChWK:    lookup.addr = CastleBase;
                  ChWQ:    lookup.addr = CastleBase + IdxW'(1);
                  ChBK:    lookup.addr = CastleBase + IdxW'(2);
                  ChBQ:    lookup.addr = CastleBase + IdxW'(3);
                  default: lookup.hit  = 1'b0;
               endcase
            end
            PH_EP: begin
               lookup.addr = EpBase + IdxW'(ep_file);
               lookup.hit  = (file_ff == 4'd0) && is_ep_file &&
                             ((beside & pawns) != 8'd0);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BOARD;
         rank_ff  <= 3'd7;
         file_ff  <= 4'd0;
         wtm_ff   <= 1'b0;
         bp4_ff   <= 8'd0;
         wp5_ff   <= 8'd0;
         bad_ff   <= 1'b0;
      end else if (char_en) begin
         phase_ff <= phase_in;
         rank_ff  <= rank_in;
         file_ff  <= file_in;
         wtm_ff   <= wtm_in;
         bp4_ff   <= bp4_in;
         wp5_ff   <= wp5_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/chess_position_zobrist_key.sv @@
`default_nettype none

// Zobrist key of a chess position given as a FEN string, in the usual
// opening-book layout. Load the 781-word random table first with write
// transfers (tuser = 1, index and word in tdata); indexes above 780 are
// dropped, and every word must be written before a character reads it.
// Then stream the string one character per transfer (tuser = 0), with tlast
// on the final character; that transfer yields exactly one result transfer
// carrying the 64-bit key and a flag for an unknown piece letter in the
// board field. Fields after the en passant field are ignored. The block
// takes one transfer every cycle unless stalled: the parser picks a table
// address in the cycle a character arrives, the table's registered read
// port returns the word in the next cycle, and it is XORed into the
// accumulator; the finished key is loaded into the output register. The
// input stalls only while a finished key sits unread in the output register
// and a second final character has reached the lookup stage behind it.
module chess_position_zobrist_key (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] char_code, [17:8] table_index, [81:18] table_word, [87:82] zero
   input  wire logic [87:0] req_tdata,
   // [0] req_type
   input  wire logic [0:0]  req_tuser,
   input  wire logic        req_tlast,
   // Result stream.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [63:0] position_key, [64] bad_piece, [71:65] zero
   output      logic [71:0] rsp_tdata
);
   import zobkey_pkg::*;

   logic [7:0]      char_code;
   logic [IdxW-1:0] table_index;
   logic [KeyW-1:0] table_word;

   logic accept;
   logic char_en;
   logic wr_en;
   logic s1_stall;
   logic s1_fire;

   lookup_type lookup;
   lookup_type s1_lookup_ff;
   logic       s1_valid_ff;

   // Random table storage; one write or one read per transfer.
   logic [KeyW-1:0] table_mem [TableDepth];
   logic [KeyW-1:0] rdata_ff;

   logic [KeyW-1:0] key_ff, key_in;
   logic            rsp_valid_ff;
   logic [KeyW-1:0] rsp_key_ff;
   logic            rsp_bad_ff;

   assign char_code   = req_tdata[7:0];
   assign table_index = req_tdata[17:8];
   assign table_word  = req_tdata[81:18];

   // The lookup stage can only hold a final character back when the
   // output register is still full.
   assign s1_stall   = s1_valid_ff && s1_lookup_ff.last && rsp_valid_ff && !rsp_tready;
   assign req_tready = !s1_stall;
   assign accept     = req_tvalid && req_tready;
   assign char_en    = accept && !req_tuser[0];
   assign wr_en      = accept && req_tuser[0] && (table_index <= LastIndex);
   assign s1_fire    = s1_valid_ff && !s1_stall;

   zobkey_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .char_en   (char_en),
      .char_code (char_code),
      .is_last   (req_tlast),
      .lookup    (lookup)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[table_index] <= table_word;
      end
   end

   // Read data holds while the lookup stage is stalled.
   always_ff @(posedge clock) begin
      if (!s1_stall) begin
         rdata_ff <= table_mem[lookup.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_stall) begin
         s1_valid_ff <= char_en;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_stall) begin
         s1_lookup_ff <= lookup;
      end
   end

   assign key_in = s1_lookup_ff.hit ? (key_ff ^ rdata_ff) : key_ff;

   // The accumulator restarts from zero once a key has been handed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (s1_fire) begin
         key_ff <= s1_lookup_ff.last ? '0 : key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_lookup_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_lookup_ff.last) begin
         rsp_key_ff <= key_in;
         rsp_bad_ff <= s1_lookup_ff.bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bad_ff, rsp_key_ff};

endmodule

`default_nettype wire

@@ bench/chess_position_zobrist_key_tb.sv @@
`default_nettype none

module chess_position_zobrist_key_tb;
   import zobkey_pkg::*;

   localparam int ClockHalf     = 6;
   localparam int ResetCycles   = 9;
   // Idle time once every key owed has been checked, before the verdict.
   localparam int DrainCycles   = 8;
   localparam int TimeoutCycles = 400000;
   localparam int IndexSpan     = 1024;
   // Characters streamed in each idling phase of the random part.
   localparam int PhaseChars    = 200;

   // Values of the request type carried on tuser.
   localparam logic TypeChar  = 1'b0;
   localparam logic TypeWrite = 1'b1;

   // One input transfer, plus an optional expected key typed in by hand.
   typedef struct {
      logic            kind;
      logic [7:0]      ch;
      logic            last;
      logic [IdxW-1:0] idx;
      logic [KeyW-1:0] word;
      logic            typed;
      logic [KeyW-1:0] typed_key;
      logic            typed_bad;
   } stream_item_type;

   // What one result transfer must carry.
   typedef struct packed {
      logic [KeyW-1:0] key;
      logic            bad;
   } key_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire logic   req_tready;
   logic [87:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        req_tlast  = 1'b0;
   wire logic   rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire logic [71:0] rsp_tdata;

   // Our own copy of the hash state: the random words, the running key and
   // the position of the parser within the position string.
   logic [KeyW-1:0] key_words [TableDepth];
   logic [KeyW-1:0] key_acc;
   phase_type       fen_field;
   logic [2:0]      rank_row;
   int              col;
   logic            white_move;
   logic            bad_seen;
   logic [7:0]      black_pawns4;
   logic [7:0]      white_pawns5;

   // Keys still owed by the block, oldest first.
   key_result_type pending_keys[$];

   int              error_count = 0;
   int              send_idle_pct;
   int              rsp_stall_pct;
   logic [7:0]      fen_text[$];
   stream_item_type directed_rows[24];

   chess_position_zobrist_key DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Parser state goes back to its reset values after every finished key.
   task automatic clear_position();
      key_acc      = '0;
      fen_field    = PH_BOARD;
      rank_row     = 3'd7;
      col          = 0;
      white_move   = 1'b0;
      bad_seen     = 1'b0;
      black_pawns4 = '0;
      white_pawns5 = '0;
   endtask

   // Applies one accepted transfer to the predicted state. A final character
   // hands back the finished key and the unknown-piece flag.
   task automatic zobrist_step(input stream_item_type it, output logic emit,
                               output logic [KeyW-1:0] key, output logic bad);
      string      order;
      int         slot;
      int         i;
      int         f;
      logic [7:0] beside;
      logic [7:0] pawns;
      order = "pPnNbBrRqQkK";
      emit  = 1'b0;
      key   = '0;
      bad   = 1'b0;
      if (it.kind == TypeWrite) begin
         // Writes past the end of the table are dropped; tlast means nothing.
         if (it.idx < TableDepth) key_words[it.idx] = it.word;
         return;
      end
      if (it.ch == ChSpace) begin
         // Every space moves to the next field, stopping at the ignored rest.
         if (fen_field != PH_REST) fen_field = phase_type'(fen_field + 3'd1);
         col = 0;
      end else begin
         case (fen_field)
            PH_BOARD: begin
               if (it.ch == ChSlash) begin
                  // Moving below the first rank wraps back to the eighth.
                  rank_row = rank_row - 3'd1;
                  col      = 0;
               end else if (it.ch >= ChOne && it.ch <= ChEight) begin
                  col = col + (it.ch - ChOne + 1);
                  if (col > 8) col = 8;
               end else begin
                  slot = -1;
                  for (i = 0; i < 12; i++) begin
                     if (order[i] == it.ch && slot < 0) slot = i;
                  end
                  if (slot < 0) begin
                     bad_seen = 1'b1;
                  end else if (col < 8) begin
                     key_acc ^= key_words[64 * slot + 8 * rank_row + col];
                     // Pawns that could capture en passant on the next move.
                     if (slot == PcBlackPawn && rank_row == 3'd3) black_pawns4[col] = 1'b1;
                     if (slot == PcWhitePawn && rank_row == 3'd4) white_pawns5[col] = 1'b1;
                  end
                  if (col < 8) col++;
               end
            end
            PH_SIDE: begin
               if (col == 0) begin
                  white_move = (it.ch == ChLowW);
                  if (white_move) key_acc ^= key_words[TurnWord];
               end
               if (col < 15) col++;
            end
            PH_CASTLE: begin
               case (it.ch)
                  ChWK:    key_acc ^= key_words[CastleBase];
                  ChWQ:    key_acc ^= key_words[CastleBase + 1];
                  ChBK:    key_acc ^= key_words[CastleBase + 2];
                  ChBQ:    key_acc ^= key_words[CastleBase + 3];
                  default: ;
               endcase
               if (col < 15) col++;
            end
            PH_EP: begin
               // Only the file letter counts, and only when a pawn of the
               // side to move stands next to it ready to capture.
               if (col == 0 && it.ch >= ChLowA && it.ch <= ChLowH) begin
                  f      = it.ch - ChLowA;
                  beside = '0;
                  if (f > 0) beside[f - 1] = 1'b1;
                  if (f < 7) beside[f + 1] = 1'b1;
                  pawns = white_move ? white_pawns5 : black_pawns4;
                  if ((beside & pawns) != 0) key_acc ^= key_words[EpBase + f];
               end
               if (col < 15) col++;
            end
            default: ;
         endcase
      end
      if (it.last) begin
         emit = 1'b1;
         key  = key_acc;
         bad  = bad_seen;
         clear_position();
      end
   endtask

   // Character transfer; the table fields are unused, so they carry noise.
   function automatic stream_item_type char_item(input logic [7:0] ch, input logic last);
      stream_item_type it;
      it.kind      = TypeChar;
      it.ch        = ch;
      it.last      = last;
      it.idx       = IdxW'($urandom);
      it.word      = {$urandom, $urandom};
      it.typed     = 1'b0;
      it.typed_key = '0;
      it.typed_bad = 1'b0;
      return it;
   endfunction

   function automatic stream_item_type write_item(input logic [IdxW-1:0] idx,
                                                  input logic [KeyW-1:0] word,
                                                  input logic last);
      stream_item_type it;
      it      = char_item(8'($urandom), last);
      it.kind = TypeWrite;
      it.idx  = idx;
      it.word = word;
      return it;
   endfunction

   // Final character whose key is known without running the predictor.
   function automatic stream_item_type keyed_item(input logic [7:0] ch,
                                                  input logic [KeyW-1:0] key,
                                                  input logic bad);
      stream_item_type it;
      it           = char_item(ch, 1'b1);
      it.typed     = 1'b1;
      it.typed_key = key;
      it.typed_bad = bad;
      return it;
   endfunction

   // Presents one transfer, after a random idle gap, and waits for it to be
   // taken. The expected key is queued at the edge where the transfer lands.
   task automatic push_item(input stream_item_type it);
      logic            emit;
      logic [KeyW-1:0] key;
      logic            bad;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, it.word, it.idx, it.ch};
      req_tuser  <= it.kind;
      req_tlast  <= it.last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      zobrist_step(it, emit, key, bad);
      if (emit) begin
         if (it.typed) pending_keys.push_back({it.typed_key, it.typed_bad});
         else pending_keys.push_back({key, bad});
      end
   endtask

   // A field separator, now and then doubled.
   task automatic add_gap();
      fen_text.push_back(ChSpace);
      if ($urandom_range(0, 99) < 5) fen_text.push_back(ChSpace);
   endtask

   // Streams position strings under one idling setting. Most strings are
   // well-formed positions with random content so that every field gets
   // parsed; the rest are short runs of arbitrary bytes. A few boards are
   // broken on purpose, some strings are cut short, and table words are
   // rewritten now and then between characters.
   task automatic run_phase(input int idle_pct, input int stall_pct);
      string officers;
      int    strings;
      int    chars;
      int    i;
      int    r;
      int    filled;
      int    d;
      int    cut;
      officers      = "nNbBrRqQkK";
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      strings       = 0;
      chars         = 0;
      while (strings < 3 || chars < PhaseChars) begin
         fen_text.delete();
         if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 99) < 20) fen_text.push_back(ChSpace);
               else fen_text.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            for (r = 0; r < 8; r++) begin
               filled = 0;
               while (filled < 8) begin
                  if ($urandom_range(0, 99) < 30) begin
                     d = $urandom_range(1, 8 - filled);
                     fen_text.push_back(8'(ChOne + d - 1));
                     filled += d;
                  end else begin
                     // Plenty of pawns, so that en passant captures turn up.
                     if ($urandom_range(0, 99) < 40) begin
                        fen_text.push_back($urandom_range(0, 1) ? "p" : "P");
                     end else begin
                        fen_text.push_back(officers[$urandom_range(0, 9)]);
                     end
                     filled++;
                  end
               end
               // Broken boards: a piece beyond column h, a stray byte, or an
               // extra rank separator that runs the ranks past the first.
               if ($urandom_range(0, 99) < 6) fen_text.push_back(officers[$urandom_range(0, 9)]);
               if ($urandom_range(0, 99) < 4) fen_text.push_back(8'($urandom_range(0, 255)));
               if (r < 7) begin
                  fen_text.push_back(ChSlash);
                  if ($urandom_range(0, 99) < 4) fen_text.push_back(ChSlash);
               end
            end
            add_gap();
            d = $urandom_range(0, 99);
            if (d < 45) fen_text.push_back(ChLowW);
            else if (d < 90) fen_text.push_back("b");
            else fen_text.push_back(8'($urandom_range(0, 255)));
            // Only the first side character counts; test that with a tail.
            if ($urandom_range(0, 99) < 10) fen_text.push_back($urandom_range(0, 1) ? "b" : "w");
            add_gap();
            if ($urandom_range(0, 99) < 25) begin
               fen_text.push_back("-");
            end else begin
               cut = fen_text.size();
               if ($urandom_range(0, 1)) fen_text.push_back(ChWK);
               if ($urandom_range(0, 1)) fen_text.push_back(ChWQ);
               if ($urandom_range(0, 1)) fen_text.push_back(ChBK);
               if ($urandom_range(0, 1)) fen_text.push_back(ChBQ);
               if (fen_text.size() == cut) fen_text.push_back("-");
            end
            if ($urandom_range(0, 99) < 10) fen_text.push_back(8'($urandom_range(0, 255)));
            add_gap();
            d = $urandom_range(0, 99);
            if (d < 40) begin
               fen_text.push_back("-");
            end else if (d < 90) begin
               fen_text.push_back(8'(ChLowA + $urandom_range(0, 7)));
               fen_text.push_back($urandom_range(0, 1) ? "3" : "6");
            end else begin
               fen_text.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 50) begin
               fen_text.push_back(ChSpace);
               fen_text.push_back("0");
               fen_text.push_back(ChSpace);
               fen_text.push_back("1");
            end
            // Truncated strings leave later fields missing.
            if ($urandom_range(0, 99) < 15) begin
               cut = $urandom_range(1, fen_text.size());
               while (fen_text.size() > cut) void'(fen_text.pop_back());
            end
         end
         for (i = 0; i < fen_text.size(); i++) begin
            if ($urandom_range(0, 99) < 2) begin
               push_item(write_item(IdxW'($urandom_range(0, IndexSpan - 1)),
                                    {$urandom, $urandom}, 1'($urandom_range(0, 1))));
            end
            push_item(char_item(fen_text[i], i == fen_text.size() - 1));
         end
         strings++;
         chars += fen_text.size();
      end
      // Hold the input idle until every key owed so far has been checked.
      req_tvalid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
   endtask

   // Result side: random backpressure, and each result transfer is checked
   // against the oldest key still owed.
   always @(posedge clock) begin : key_checker
      key_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_keys.size() == 0) begin
               report_mismatch($sformatf("key %h arrived with none owed", rsp_tdata[63:0]));
            end else begin
               want = pending_keys.pop_front();
               if (rsp_tdata[63:0] !== want.key) begin
                  report_mismatch($sformatf("position_key %h, expected %h",
                                            rsp_tdata[63:0], want.key));
               end
               if (rsp_tdata[64] !== want.bad) begin
                  report_mismatch($sformatf("bad_piece %b, expected %b",
                                            rsp_tdata[64], want.bad));
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      int i;
      clear_position();
      send_idle_pct = 6;
      rsp_stall_pct = 72;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole table first, so no character ever reads a word that
      // was never written.
      for (i = 0; i < TableDepth; i++) begin
         push_item(write_item(IdxW'(i), {$urandom, $urandom}, 1'($urandom_range(0, 1))));
      end

      // Directed strings. Rows with a typed key can be worked out by eye;
      // the last row goes through the predictor.
      directed_rows = '{
         keyed_item("8", '0, 1'b0),          // empty board straight after reset
         keyed_item(8'h00, '0, 1'b1),        // lowest code is an unknown piece
         keyed_item(8'hFF, '0, 1'b1),        // so is the highest
         char_item("8", 1'b0),
         keyed_item("p", '0, 1'b0),          // piece beyond column h adds nothing
         write_item(TurnWord, '0, 1'b0),
         write_item(IdxW'(IndexSpan - 1), '1, 1'b1),  // past the table, tlast set
         char_item(ChSpace, 1'b0),
         keyed_item(ChLowW, '0, 1'b0),
         write_item(TurnWord, '1, 1'b0),
         char_item(ChSpace, 1'b0),
         keyed_item(ChLowW, '1, 1'b0),       // white to move picks the turn word
         char_item(ChSpace, 1'b0),           // two spaces: side field left empty
         char_item(ChSpace, 1'b0),
         char_item(ChWK, 1'b0),
         char_item("x", 1'b0),               // foreign letter in castling field
         keyed_item(ChWK, '0, 1'b0),         // the same castling word twice
         char_item(ChSpace, 1'b0),
         char_item(ChSpace, 1'b0),
         char_item(ChSpace, 1'b0),
         char_item("e", 1'b0),               // en passant file with no pawn beside
         char_item(ChSpace, 1'b0),
         keyed_item(ChLowW, '0, 1'b0),       // fields after en passant are ignored
         char_item("P", 1'b1)
      };
      foreach (directed_rows[n]) push_item(directed_rows[n]);

      // Random part: slow receiver, then slow sender, then full speed.
      run_phase(6, 72);
      run_phase(72, 6);
      run_phase(0, 0);

      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #(TimeoutCycles * 2 * ClockHalf);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
